// ----- hw/rtl/rlqs_pkg.sv -----
`default_nettype none

package rlqs_pkg;

  // Store geometry
  localparam int RUN_DEPTH = 64;
  localparam int IDX_W     = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CNT_W     = $clog2(RUN_DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int SUM_W     = 64;
  localparam int ITEMS_W   = DATA_W + CNT_W;
  localparam int ENTRY_W   = 2 * DATA_W;

  // Request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_OVER = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_DRAIN,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] run_count;
    logic [DATA_W-1:0] run_value;
    logic [DATA_W-1:0] take_amount;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] taken_sum;
    status_t          status;
  } out_item_t;

  // Multiply-accumulate control
  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

  // Advance a circular index, wrapping at the store depth
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(RUN_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rlqs_ram.sv -----
`default_nettype none

module rlqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rlqs_mac.sv -----
`default_nettype none

module rlqs_mac (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rlqs_pkg::mac_ctl_t            ctl,
  input  wire logic [rlqs_pkg::DATA_W-1:0]   mul_a,
  input  wire logic [rlqs_pkg::DATA_W-1:0]   mul_b,
  output logic      [rlqs_pkg::SUM_W-1:0]    acc
);

  import rlqs_pkg::*;

  logic [SUM_W-1:0] prod_r;
  logic             prod_vld_r;
  logic [SUM_W-1:0] acc_r;

  // Product stage
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= SUM_W'(mul_a) * SUM_W'(mul_b);
    end
  end

  // Product valid flag
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.en;
    end
  end

  // Accumulate, wrapping modulo 2^64
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ----- hw/rtl/run_length_queue_sum.sv -----
`default_nettype none

// Channel   Ports                          Payload
// input     in_valid, in_stall, in_item    push run / take amount
// result    out_valid, out_stall, out_item taken_sum, status
//
// One request is worked at a time; the run store is a registered-read RAM of {count, value}.
// A push or a rejected or zero take goes from S_IDLE straight to S_DONE, which loads the result.
// A take runs S_READ (one RAM read) and S_CALC (one multiply) for each run touched, then
// S_DRAIN to drain the accumulator and S_DONE to load the result register.
// Reset clears the state, indexes, counts and output valid only; store contents need no clearing.
// A stalled result holds the output register; the finished request waits in S_DONE until it frees.

module run_length_queue_sum (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rlqs_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rlqs_pkg::out_item_t      out_item
);

  import rlqs_pkg::*;

  fsm_t               fsm_r, fsm_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   runs_r, runs_nxt;
  logic [ITEMS_W-1:0] items_r, items_nxt;
  logic [DATA_W-1:0]  left_r, left_nxt;
  status_t            stat_r, stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r;

  logic               out_load;
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [ENTRY_W-1:0] ram_rd_data;
  mac_ctl_t           mac_ctl;
  logic [DATA_W-1:0]  mac_a;
  logic [DATA_W-1:0]  mac_b;
  logic [SUM_W-1:0]   mac_acc;

  logic [DATA_W-1:0]  have;
  logic [DATA_W-1:0]  use_cnt;

  rlqs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RUN_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  rlqs_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .mul_a (mac_a),
    .mul_b (mac_b),
    .acc   (mac_acc)
  );

  assign have    = ram_rd_data[ENTRY_W-1:DATA_W];
  assign use_cnt = (left_r < have) ? left_r : have;

  // Next state and datapath control
  always_comb begin
    fsm_nxt     = fsm_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    runs_nxt    = runs_r;
    items_nxt   = items_r;
    left_nxt    = left_r;
    stat_nxt    = stat_r;
    out_load    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = tail_r;
    ram_wr_data = {in_item.run_count, in_item.run_value};
    ram_rd_en   = 1'b0;
    mac_ctl     = '0;
    mac_a       = use_cnt;
    mac_b       = ram_rd_data[DATA_W-1:0];
    case (fsm_r)
      S_IDLE: begin
        if (in_valid) begin
          mac_ctl.clr = 1'b1;
          stat_nxt    = STAT_OK;
          fsm_nxt     = S_DONE;
          if (in_item.req_type == REQ_PUSH) begin
            if (in_item.run_count != '0) begin
              if (runs_r == CNT_W'(RUN_DEPTH)) begin
                stat_nxt = STAT_FULL;
              end else begin
                ram_wr_en = 1'b1;
                tail_nxt  = next_idx(tail_r);
                runs_nxt  = runs_r + 1'b1;
                items_nxt = items_r + ITEMS_W'(in_item.run_count);
              end
            end
          end else begin
            if (ITEMS_W'(in_item.take_amount) > items_r) begin
              stat_nxt = STAT_OVER;
            end else if (in_item.take_amount != '0) begin
              left_nxt = in_item.take_amount;
              fsm_nxt  = S_READ;
            end
          end
        end
      end
      S_READ: begin
        ram_rd_en = 1'b1;
        fsm_nxt   = S_CALC;
      end
      S_CALC: begin
        mac_ctl.en = 1'b1;
        left_nxt   = left_r - use_cnt;
        items_nxt  = items_r - ITEMS_W'(use_cnt);
        if (use_cnt == have) begin
          // Whole run consumed: drop it
          head_nxt = next_idx(head_r);
          runs_nxt = runs_r - 1'b1;
        end else begin
          // Partial run: write back the remaining count
          ram_wr_en   = 1'b1;
          ram_wr_addr = head_r;
          ram_wr_data = {have - use_cnt, ram_rd_data[DATA_W-1:0]};
        end
        fsm_nxt = (left_r == use_cnt) ? S_DRAIN : S_READ;
      end
      S_DRAIN: begin
        fsm_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          fsm_nxt  = S_IDLE;
        end
      end
      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (fsm_r != S_IDLE);

  // Output valid: set on load, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      runs_r      <= '0;
      items_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      runs_r      <= runs_nxt;
      items_r     <= items_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    stat_r <= stat_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.taken_sum <= mac_acc;
      out_item_r.status    <= stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Run count never exceeds the store depth
  a_runs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    runs_r <= CNT_W'(RUN_DEPTH))
    else $error("run count beyond store depth");

  // An empty store holds no items
  a_empty_items: assert property (@(posedge clk) disable iff (!rst_n)
    (runs_r == '0) |-> (items_r == '0))
    else $error("items held with no runs");

  // A walk step always has items left to take and a run to take from
  a_walk_live: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_CALC) |-> (left_r != '0 && runs_r != '0 && have != '0))
    else $error("take walk on empty state");

  // A rejected request reports a zero sum
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != STAT_OK) |-> (out_item.taken_sum == '0))
    else $error("nonzero sum on rejected request");

endmodule

`default_nettype wire
